// ===== design/fpa_pkg.sv =====
// Shared types, command codes and saturation helpers for the fixed-point ALU.
package fpa_pkg;

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_INC      = 4'd4,
    CMD_DEC      = 4'd5,
    CMD_CMP      = 4'd6,
    CMD_MIN      = 4'd7,
    CMD_MAX      = 4'd8,
    CMD_FROM_INT = 4'd9,
    CMD_TO_INT   = 4'd10
  } fpa_cmd_t;

  localparam logic [64:0] MAG_POS_MAX = 65'h0_7FFF_FFFF;
  localparam logic [64:0] MAG_NEG_MAX = 65'h0_8000_0000;

  // Side-band carried alongside the divider: everything other than the quotient
  typedef struct packed {
    logic [3:0]  cmd;
    logic        neg;
    logic        a_neg;
    logic [31:0] res;
    logic        ovf;
    logic        lt;
    logic        eq;
    logic        gt;
    logic [63:0] prod;
  } fpa_side_t;

  // Sign and magnitude to saturated 32-bit value; returns {ovf, value}
  function automatic logic [32:0] sat_mag(input logic neg, input logic [64:0] mag);
    logic [64:0] negv;
    negv = 65'd0 - mag;
    if (neg) begin
      if (mag > MAG_NEG_MAX) return {1'b1, 32'h8000_0000};
      return {1'b0, negv[31:0]};
    end
    if (mag > MAG_POS_MAX) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, mag[31:0]};
  endfunction

  // 33-bit signed sum to saturated 32-bit value; returns {ovf, value}
  function automatic logic [32:0] sat_sum(input logic [32:0] s);
    if (s[32] != s[31]) return s[32] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
    return {1'b0, s[31:0]};
  endfunction

endpackage

// ===== design/fpa_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side-band payload.
module fpa_divider #(
  parameter int NB = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [NB-1:0]       in_num,
  input  logic [31:0]         in_den,
  input  fpa_pkg::fpa_side_t  in_side,
  output logic                out_valid,
  output logic [NB-1:0]       out_quo,
  output logic [31:0]         out_rem,
  output logic [31:0]         out_den,
  output fpa_pkg::fpa_side_t  out_side
);
  import fpa_pkg::*;

  logic            vld_r  [NB+1];
  logic [NB-1:0]   num_r  [NB+1];
  logic [NB-1:0]   quo_r  [NB+1];
  logic [31:0]     rem_r  [NB+1];
  logic [31:0]     den_r  [NB+1];
  fpa_side_t       side_r [NB+1];

  // stage zero is the entry point
  assign vld_r[0]  = in_valid;
  assign num_r[0]  = in_num;
  assign quo_r[0]  = '0;
  assign rem_r[0]  = '0;
  assign den_r[0]  = in_den;
  assign side_r[0] = in_side;

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic [32:0]   trial;
    logic [32:0]   diff;
    logic          take;
    logic [31:0]   rem_nxt;
    logic [NB-1:0] quo_nxt;

    // shift in next numerator bit, subtract if it fits
    always_comb begin
      trial   = {rem_r[k], num_r[k][NB-1]};
      diff    = trial - {1'b0, den_r[k]};
      take    = trial >= {1'b0, den_r[k]};
      rem_nxt = take ? diff[31:0] : trial[31:0];
      quo_nxt = {quo_r[k][NB-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        num_r[k+1]  <= {num_r[k][NB-2:0], 1'b0};
        quo_r[k+1]  <= quo_nxt;
        rem_r[k+1]  <= rem_nxt;
        den_r[k+1]  <= den_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = vld_r[NB];
  assign out_quo   = quo_r[NB];
  assign out_rem   = rem_r[NB];
  assign out_den   = den_r[NB];
  assign out_side  = side_r[NB];

endmodule

// ===== design/fixed_point_alu.sv =====
// Every command takes the same path: input stage, divider stages, final stage.
// Throughput: one beat per cycle unless stalled; one divider stage per quotient bit.
// Stall on the result side freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
module fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_cmd,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_result,
  output logic        out_less,
  output logic        out_equal,
  output logic        out_greater,
  output logic        out_overflow,
  output logic        out_div_zero
);
  import fpa_pkg::*;

  localparam int NB = 32 + FRAC_BITS;
  localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // input stage: operands and magnitudes
  logic        s1_valid_r;
  logic [3:0]  s1_cmd_r;
  logic [31:0] s1_a_r, s1_b_r, s1_ma_r, s1_mb_r;
  logic [31:0] ma_nxt, mb_nxt;

  always_comb begin
    ma_nxt = in_operand_a[31] ? 32'(-in_operand_a) : in_operand_a;
    mb_nxt = in_operand_b[31] ? 32'(-in_operand_b) : in_operand_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r <= in_cmd;
      s1_a_r   <= in_operand_a;
      s1_b_r   <= in_operand_b;
      s1_ma_r  <= ma_nxt;
      s1_mb_r  <= mb_nxt;
    end
  end

  // simple ops, product and side-band for the divider pipe
  fpa_side_t side;
  logic signed [31:0] sa, sb;
  logic [32:0] tmp;

  always_comb begin
    sa = s1_a_r;
    sb = s1_b_r;
    side       = '0;
    tmp        = '0;
    side.cmd   = s1_cmd_r;
    side.neg   = s1_a_r[31] ^ s1_b_r[31];
    side.a_neg = s1_a_r[31];
    side.prod  = 64'(s1_ma_r) * 64'(s1_mb_r);
    case (s1_cmd_r)
      CMD_ADD:      tmp = sat_sum(33'(sa) + 33'(sb));
      CMD_SUB:      tmp = sat_sum(33'(sa) - 33'(sb));
      CMD_INC:      tmp = sat_sum(33'(sa) + 33'sd1);
      CMD_DEC:      tmp = sat_sum(33'(sa) - 33'sd1);
      CMD_MIN:      tmp = {1'b0, (sa < sb) ? s1_a_r : s1_b_r};
      CMD_MAX:      tmp = {1'b0, (sa > sb) ? s1_a_r : s1_b_r};
      CMD_FROM_INT: tmp = sat_mag(s1_a_r[31], 65'({s1_ma_r, FRAC_BITS'(0)}));
      CMD_TO_INT:   tmp = {1'b0, 32'(sa >>> FRAC_BITS)};
      CMD_CMP: begin
        side.lt = sa < sb;
        side.eq = sa == sb;
        side.gt = sa > sb;
      end
      default: tmp = '0;
    endcase
    side.ovf = tmp[32];
    side.res = tmp[31:0];
  end

  logic            dv_valid;
  logic [NB-1:0]   dv_quo;
  logic [31:0]     dv_rem, dv_den;
  fpa_side_t       dv_side;

  fpa_divider #(.NB(NB)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s1_valid_r),
    .in_num    ({s1_ma_r, FRAC_BITS'(0)}),
    .in_den    (s1_mb_r),
    .in_side   (side),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_rem   (dv_rem),
    .out_den   (dv_den),
    .out_side  (dv_side)
  );

  // final stage: rounding and saturation of mul and div
  logic [32:0] fin;
  logic [63:0] pr;
  logic [NB:0] qr;
  logic        dz;

  always_comb begin
    pr  = (dv_side.prod + HALF) >> FRAC_BITS;
    qr  = {1'b0, dv_quo} + ((({dv_rem, 1'b0}) >= {1'b0, dv_den}) ? (NB+1)'(1) : '0);
    dz  = 1'b0;
    fin = {dv_side.ovf, dv_side.res};
    case (dv_side.cmd)
      CMD_MUL: fin = sat_mag(dv_side.neg, 65'(pr));
      CMD_DIV: begin
        if (dv_den == '0) begin
          dz  = 1'b1;
          fin = {1'b0, dv_side.a_neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end else begin
          fin = sat_mag(dv_side.neg, 65'(qr));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result   <= fin[31:0];
      out_overflow <= fin[32];
      out_div_zero <= dz;
      out_less     <= dv_side.lt;
      out_equal    <= dv_side.eq;
      out_greater  <= dv_side.gt;
    end
  end

`ifndef SYNTHESIS
  a_dz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |-> !out_overflow) else $error("div_zero with overflow");
  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_less, out_equal, out_greater}) <= 1)
    else $error("compare flags not exclusive");
  a_dz_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |-> out_result == 32'h7FFF_FFFF || out_result == 32'h8000_0000)
    else $error("zero divisor result not saturated");
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
`endif

endmodule
